[hw/rtl/sound_fade_envelope_defines.svh]
// Assertion helpers shared by the envelope modules.
// They expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef SOUND_FADE_ENVELOPE_DEFINES_SVH
`define SOUND_FADE_ENVELOPE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/sfe_pkg.sv]
package sfe_pkg;

  // Default width of the time accumulator and the stored lengths.
  localparam int TIME_BITS_DEF = 24;

  // Gain is Q0.16; the ramp divider produces one quotient bit per step.
  localparam int GAIN_BITS = 16;

  localparam int FRAME_W    = 16;
  localparam int IN_TIME_W  = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_PLAY = 2'd1;
  localparam logic [1:0] ACT_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLUME  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 1'b1;

  localparam logic [GAIN_BITS-1:0] MAX_VOLUME_RST = '1;

  typedef enum logic [2:0] {
    MODE_STOP     = 3'd0,
    MODE_DELAY    = 3'd1,
    MODE_FADE_IN  = 3'd2,
    MODE_PLAY     = 3'd3,
    MODE_FADE_OUT = 3'd4
  } sfe_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic mul;
    logic div_start;
    logic gain_load;
    logic publish;
  } sfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } sfe_status_t;

endpackage

[hw/rtl/sfe_div.sv]
module sfe_div #(
  parameter int TIME_BITS = sfe_pkg::TIME_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [TIME_BITS+sfe_pkg::GAIN_BITS-1:0] dividend,
  input  logic [TIME_BITS-1:0]                   divisor,
  output logic                                   done,
  output logic [sfe_pkg::GAIN_BITS-1:0]          quotient
);

  localparam int GB    = sfe_pkg::GAIN_BITS;
  localparam int CNT_W = $clog2(GB);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GB - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [TIME_BITS-1:0] rem_nxt;
  logic [GB-1:0]        low_r;
  logic [GB-1:0]        quo_r;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   diff;
  logic                 ge;

  // The quotient is known to fit in GB bits, so the upper dividend bits are
  // already below the divisor and serve as the starting remainder.
  always_comb begin
    trial   = {rem_r, low_r[GB-1]};
    diff    = trial - {1'b0, divisor};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[TIME_BITS+GB-1:GB];
      low_r <= dividend[GB-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[GB-2:0], 1'b0};
      quo_r <= {quo_r[GB-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/sfe_dp.sv]
`include "sound_fade_envelope_defines.svh"

module sfe_dp #(
  parameter int TIME_BITS = sfe_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sfe_pkg::sfe_cmd_t                  cmd,
  output sfe_pkg::sfe_status_t               status,
  input  logic [1:0]                         in_action,
  input  logic [sfe_pkg::FRAME_W-1:0]        in_frame_time,
  input  logic [sfe_pkg::IN_TIME_W-1:0]      in_delay_time,
  input  logic [sfe_pkg::IN_TIME_W-1:0]      in_fade_time,
  input  logic                               in_restart_now,
  input  logic                               cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [sfe_pkg::GAIN_BITS-1:0]      out_gain,
  output logic [2:0]                         out_mode,
  output logic                               out_start_pulse,
  output logic                               out_stop_pulse,
  output logic                               out_started,
  output logic                               out_voice_held
);

  localparam int GB     = sfe_pkg::GAIN_BITS;
  localparam int EXT_W  = (TIME_BITS > sfe_pkg::IN_TIME_W ? TIME_BITS : sfe_pkg::IN_TIME_W) + 1;
  localparam int PROD_W = TIME_BITS + GB;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  function automatic logic [TIME_BITS-1:0] sat_time(input logic [EXT_W-1:0] v);
    if (v > EXT_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return v[TIME_BITS-1:0];
  endfunction

  // Configuration.
  logic [GB-1:0] max_volume_r;
  logic          loop_enable_r;

  // Captured request.
  logic [1:0]                    item_action_r;
  logic [sfe_pkg::FRAME_W-1:0]   item_frame_r;
  logic [sfe_pkg::IN_TIME_W-1:0] item_delay_r;
  logic [sfe_pkg::IN_TIME_W-1:0] item_fade_r;
  logic                          item_restart_r;

  // Envelope state.
  sfe_pkg::sfe_mode_t   mode_r,  mode_nxt;
  logic [TIME_BITS-1:0] acc_r,   acc_nxt;
  logic [TIME_BITS-1:0] delay_len_r, delay_len_nxt;
  logic [TIME_BITS-1:0] fade_in_len_r, fade_in_len_nxt;
  logic [TIME_BITS-1:0] fade_out_len_r, fade_out_len_nxt;
  logic [GB-1:0]        gain_r,  gain_nxt;
  logic                 started_r, started_nxt;
  logic                 voice_r, voice_nxt;
  logic                 start_p_r, start_p_nxt;
  logic                 stop_p_r, stop_p_nxt;

  // Ramp arithmetic.
  logic                 need_div_r, need_div_nxt;
  logic [TIME_BITS-1:0] num_r, num_nxt;
  logic [TIME_BITS-1:0] div_len_r, div_len_nxt;
  logic [PROD_W-1:0]    product_r;
  logic                 div_done;
  logic [GB-1:0]        div_quotient;

  // Result register.
  logic [GB-1:0] out_gain_r;
  logic [2:0]    out_mode_r;
  logic          out_start_r;
  logic          out_stop_r;
  logic          out_started_r;
  logic          out_voice_r;

  logic [EXT_W-1:0]     acc_sum;
  logic [TIME_BITS-1:0] acc_sat;
  logic [TIME_BITS-1:0] fade_sat;
  logic [TIME_BITS-1:0] delay_sat;

  assign acc_sum   = EXT_W'(acc_r) + EXT_W'(item_frame_r);
  assign acc_sat   = sat_time(acc_sum);
  assign fade_sat  = sat_time(EXT_W'(item_fade_r));
  assign delay_sat = sat_time(EXT_W'(item_delay_r));

  always_comb begin
    sfe_pkg::sfe_mode_t m;
    logic               entered;
    logic               fi_done;
    m                = mode_r;
    entered          = 1'b0;
    fi_done          = 1'b0;
    mode_nxt         = mode_r;
    acc_nxt          = acc_r;
    delay_len_nxt    = delay_len_r;
    fade_in_len_nxt  = fade_in_len_r;
    fade_out_len_nxt = fade_out_len_r;
    gain_nxt         = gain_r;
    started_nxt      = started_r;
    voice_nxt        = voice_r;
    start_p_nxt      = 1'b0;
    stop_p_nxt       = 1'b0;
    need_div_nxt     = 1'b0;
    num_nxt          = num_r;
    div_len_nxt      = div_len_r;
    case (item_action_r)
      sfe_pkg::ACT_TICK: begin
        if (!voice_r) begin
          started_nxt = 1'b0;
        end else if (mode_r != sfe_pkg::MODE_STOP) begin
          acc_nxt = acc_sat;
          if (mode_r == sfe_pkg::MODE_DELAY && acc_sat >= delay_len_r) begin
            acc_nxt     = '0;
            m           = sfe_pkg::MODE_FADE_IN;
            started_nxt = 1'b1;
            start_p_nxt = 1'b1;
            entered     = 1'b1;
          end
          if (m == sfe_pkg::MODE_FADE_IN) begin
            // A fade-in entered from the delay in this tick starts at time zero.
            fi_done = entered ? (fade_in_len_r == '0) : (acc_sat >= fade_in_len_r);
            if (fi_done) begin
              acc_nxt  = '0;
              m        = sfe_pkg::MODE_PLAY;
              gain_nxt = max_volume_r;
            end else begin
              need_div_nxt = 1'b1;
              num_nxt      = acc_nxt;
              div_len_nxt  = fade_in_len_r;
            end
          end
          if (m == sfe_pkg::MODE_PLAY) begin
            if (!loop_enable_r) begin
              m = sfe_pkg::MODE_STOP;
            end
          end else if (m == sfe_pkg::MODE_FADE_OUT) begin
            if (acc_sat >= fade_out_len_r) begin
              acc_nxt     = '0;
              m           = sfe_pkg::MODE_STOP;
              gain_nxt    = '0;
              started_nxt = 1'b0;
              voice_nxt   = 1'b0;
              stop_p_nxt  = 1'b1;
            end else begin
              need_div_nxt = 1'b1;
              num_nxt      = fade_out_len_r - acc_sat;
              div_len_nxt  = fade_out_len_r;
            end
          end
          mode_nxt = m;
        end
      end
      sfe_pkg::ACT_PLAY: begin
        // A restart releases a voice that is still sounding before the new play.
        if (item_restart_r && voice_r && mode_r != sfe_pkg::MODE_FADE_OUT &&
            mode_r != sfe_pkg::MODE_STOP) begin
          stop_p_nxt = 1'b1;
        end
        voice_nxt = 1'b1;
        if (item_delay_r == '0 && item_fade_r == '0) begin
          gain_nxt    = max_volume_r;
          start_p_nxt = 1'b1;
        end
        started_nxt      = 1'b1;
        fade_in_len_nxt  = fade_sat;
        fade_out_len_nxt = '0;
        delay_len_nxt    = delay_sat;
        acc_nxt          = '0;
        mode_nxt         = sfe_pkg::MODE_DELAY;
      end
      sfe_pkg::ACT_STOP: begin
        started_nxt = 1'b0;
        if (voice_r && mode_r != sfe_pkg::MODE_FADE_OUT && mode_r != sfe_pkg::MODE_STOP) begin
          acc_nxt          = '0;
          fade_out_len_nxt = fade_sat;
          if (fade_sat == '0) begin
            mode_nxt   = sfe_pkg::MODE_STOP;
            voice_nxt  = 1'b0;
            stop_p_nxt = 1'b1;
          end else begin
            mode_nxt = sfe_pkg::MODE_FADE_OUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_volume_r   <= sfe_pkg::MAX_VOLUME_RST;
      loop_enable_r  <= 1'b0;
      mode_r         <= sfe_pkg::MODE_STOP;
      acc_r          <= '0;
      delay_len_r    <= '0;
      fade_in_len_r  <= '0;
      fade_out_len_r <= '0;
      gain_r         <= '0;
      started_r      <= 1'b0;
      voice_r        <= 1'b0;
      start_p_r      <= 1'b0;
      stop_p_r       <= 1'b0;
      need_div_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sfe_pkg::CFG_MAX_VOLUME:  max_volume_r  <= cfg_wdata[GB-1:0];
          sfe_pkg::CFG_LOOP_ENABLE: loop_enable_r <= cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (cmd.eval) begin
        mode_r         <= mode_nxt;
        acc_r          <= acc_nxt;
        delay_len_r    <= delay_len_nxt;
        fade_in_len_r  <= fade_in_len_nxt;
        fade_out_len_r <= fade_out_len_nxt;
        gain_r         <= gain_nxt;
        started_r      <= started_nxt;
        voice_r        <= voice_nxt;
        start_p_r      <= start_p_nxt;
        stop_p_r       <= stop_p_nxt;
        need_div_r     <= need_div_nxt;
      end else if (cmd.gain_load) begin
        gain_r <= div_quotient;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_action_r  <= in_action;
      item_frame_r   <= in_frame_time;
      item_delay_r   <= in_delay_time;
      item_fade_r    <= in_fade_time;
      item_restart_r <= in_restart_now;
    end
    if (cmd.eval) begin
      num_r     <= num_nxt;
      div_len_r <= div_len_nxt;
    end
    if (cmd.mul) begin
      product_r <= PROD_W'(num_r) * PROD_W'(max_volume_r);
    end
    if (cmd.publish) begin
      out_gain_r    <= gain_r;
      out_mode_r    <= mode_r;
      out_start_r   <= start_p_r;
      out_stop_r    <= stop_p_r;
      out_started_r <= started_r;
      out_voice_r   <= voice_r;
    end
  end

  sfe_div #(
    .TIME_BITS (TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (product_r),
    .divisor  (div_len_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign status.need_div = need_div_r;
  assign status.div_done = div_done;

  assign out_gain        = out_gain_r;
  assign out_mode        = out_mode_r;
  assign out_start_pulse = out_start_r;
  assign out_stop_pulse  = out_stop_r;
  assign out_started     = out_started_r;
  assign out_voice_held  = out_voice_r;

  // A release leaves the voice free, except for a restart, which takes a new voice in delay.
  `SFE_ASSERT_NEXT(a_ramp_in_range, cmd.gain_load, gain_r <= max_volume_r, "ramp gain above peak")
  `SFE_ASSERT_NEXT(a_release_drops_voice, cmd.eval && stop_p_nxt, !voice_r || mode_r == sfe_pkg::MODE_DELAY, "voice kept")
  `SFE_ASSERT_NEXT(a_divisor_nonzero, cmd.eval && need_div_nxt, div_len_r != '0, "ramp with zero length")

endmodule

[hw/rtl/sfe_ctrl.sv]
`include "sound_fade_envelope_defines.svh"

module sfe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  sfe_pkg::sfe_status_t status,
  output sfe_pkg::sfe_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV_START,
    S_DIV_WAIT,
    S_PUBLISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // The product is formed every time; only a ramp goes on to the divider.
        cmd.mul   = 1'b1;
        state_nxt = status.need_div ? S_DIV_START : S_PUBLISH;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.gain_load = 1'b1;
          state_nxt     = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (slot_free) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  `SFE_ASSERT_NEXT(a_accept_starts_eval, in_valid && !in_stall, state_r == S_EVAL, "request not evaluated")
  `SFE_ASSERT_SAME(a_div_only_for_ramp, cmd.div_start, status.need_div, "divider started without a ramp")
  `SFE_ASSERT_SAME(a_done_while_waiting, status.div_done, state_r == S_DIV_WAIT, "divider done out of turn")

endmodule

[hw/rtl/sound_fade_envelope.sv]
// Each request is captured, evaluated and multiplied; a step that lands inside a fade ramp
// also passes through a 16-step restoring divider, which forms the ramp gain.
// One request at a time: the next is accepted the cycle after the result is loaded into
// the output register, which waits while out_stall holds a previous result.
// Reset (rst_n, synchronous, active low) clears the envelope to stop with zero gain,
// sets max_volume to full scale and loop_enable to 0, and empties the output register.
module sound_fade_envelope #(
  parameter int TIME_BITS = sfe_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_action,
  input  logic [sfe_pkg::FRAME_W-1:0]     in_frame_time,
  input  logic [sfe_pkg::IN_TIME_W-1:0]   in_delay_time,
  input  logic [sfe_pkg::IN_TIME_W-1:0]   in_fade_time,
  input  logic                            in_restart_now,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfe_pkg::GAIN_BITS-1:0]   out_gain,
  output logic [2:0]                      out_mode,
  output logic                            out_start_pulse,
  output logic                            out_stop_pulse,
  output logic                            out_started,
  output logic                            out_voice_held,
  input  logic                            cfg_we,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  sfe_pkg::sfe_cmd_t    cmd;
  sfe_pkg::sfe_status_t status;

  sfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sfe_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_action       (in_action),
    .in_frame_time   (in_frame_time),
    .in_delay_time   (in_delay_time),
    .in_fade_time    (in_fade_time),
    .in_restart_now  (in_restart_now),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_gain        (out_gain),
    .out_mode        (out_mode),
    .out_start_pulse (out_start_pulse),
    .out_stop_pulse  (out_stop_pulse),
    .out_started     (out_started),
    .out_voice_held  (out_voice_held)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import sfe_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [1:0]           action;
    logic [FRAME_W-1:0]   frame;
    logic [IN_TIME_W-1:0] delay;
    logic [IN_TIME_W-1:0] fade;
    logic                 restart;
  } env_request_t;

  typedef struct packed {
    logic [GAIN_BITS-1:0] gain;
    sfe_mode_t            mode;
    logic                 start_p;
    logic                 stop_p;
    logic                 started;
    logic                 held;
  } env_report_t;

  typedef struct packed {
    env_request_t req;
    logic         typed;
    env_report_t  want;
  } env_row_t;

  localparam env_report_t NO_REPORT = '0;
  localparam env_report_t IDLE_REPORT = '{16'd0, MODE_STOP, 1'b0, 1'b0, 1'b0, 1'b0};

  // Directed requests. Rows with typed set carry a hand-written expectation.
  localparam env_row_t DIRECTED [0:25] = '{
    '{'{ACT_TICK, 16'h1234, 24'd0, 24'd0, 1'b0}, 1'b1, IDLE_REPORT},
    '{'{ACT_UNUSED, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1}, 1'b1, IDLE_REPORT},
    '{'{ACT_STOP, 16'd0, 24'd0, 24'd0, 1'b0}, 1'b1, IDLE_REPORT},
    '{'{ACT_PLAY, 16'd0, 24'd0, 24'd0, 1'b0}, 1'b1,
      '{16'hFFFF, MODE_DELAY, 1'b1, 1'b0, 1'b1, 1'b1}},
    '{'{ACT_TICK, 16'd0, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_STOP, 16'd0, 24'd0, 24'd5, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'd100, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_PLAY, 16'd0, 24'd100, 24'd1000, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'd50, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'd60, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'd500, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'hFFFF, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_PLAY, 16'd0, 24'd0, 24'hFFFFFF, 1'b1}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'hFFFF, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'hFFFF, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_STOP, 16'd0, 24'd0, 24'hFFFFFF, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'hFFFF, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_STOP, 16'd0, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'h8000, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_PLAY, 16'd0, 24'd5, 24'd5, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_PLAY, 16'd0, 24'd0, 24'd0, 1'b1}, 1'b1,
      '{16'hFFFF, MODE_DELAY, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{'{ACT_STOP, 16'd0, 24'd0, 24'd0, 1'b0}, 1'b1,
      '{16'hFFFF, MODE_STOP, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_TICK, 16'hFFFF, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_PLAY, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_STOP, 16'd0, 24'd0, 24'd1, 1'b0}, 1'b0, NO_REPORT},
    '{'{ACT_TICK, 16'd1, 24'd0, 24'd0, 1'b0}, 1'b0, NO_REPORT}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_action = ACT_TICK;
  logic [FRAME_W-1:0]    in_frame_time = '0;
  logic [IN_TIME_W-1:0]  in_delay_time = '0;
  logic [IN_TIME_W-1:0]  in_fade_time = '0;
  logic                  in_restart_now = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [GAIN_BITS-1:0]  out_gain;
  logic [2:0]            out_mode;
  logic                  out_start_pulse;
  logic                  out_stop_pulse;
  logic                  out_started;
  logic                  out_voice_held;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sound_fade_envelope dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_frame_time  (in_frame_time),
    .in_delay_time  (in_delay_time),
    .in_fade_time   (in_fade_time),
    .in_restart_now (in_restart_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_gain       (out_gain),
    .out_mode       (out_mode),
    .out_start_pulse(out_start_pulse),
    .out_stop_pulse (out_stop_pulse),
    .out_started    (out_started),
    .out_voice_held (out_voice_held),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  // Envelope state as the testbench expects it.
  logic [GAIN_BITS-1:0] cfg_peak = '1;
  logic                 cfg_loop = 1'b0;
  sfe_mode_t            env_mode = MODE_STOP;
  logic [TW-1:0]        env_acc = '0;
  logic [TW-1:0]        env_delay = '0;
  logic [TW-1:0]        env_fin = '0;
  logic [TW-1:0]        env_fout = '0;
  logic [GAIN_BITS-1:0] env_gain = '0;
  logic                 env_started = 1'b0;
  logic                 env_voice = 1'b0;

  env_report_t pending_reports [$];
  int requests_sent = 0;
  int results_seen = 0;
  int fail_count = 0;
  int settings_used = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [TW-1:0] add_time(logic [TW-1:0] acc, logic [FRAME_W-1:0] frame);
    logic [TW:0] sum;
    sum = {1'b0, acc} + frame;
    return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  endfunction

  function automatic logic [GAIN_BITS-1:0] ramp_gain(logic [TW-1:0] num, logic [TW-1:0] den);
    logic [TW+GAIN_BITS-1:0] prod;
    prod = num * cfg_peak;
    return GAIN_BITS'(prod / den);
  endfunction

  // Returns 1 when the voice is released at once.
  function automatic logic stop_voice(logic [TW-1:0] len);
    env_started = 1'b0;
    if (!env_voice || env_mode == MODE_FADE_OUT || env_mode == MODE_STOP)
      return 1'b0;
    env_acc = '0;
    env_fout = len;
    if (len == '0) begin
      env_mode = MODE_STOP;
      env_voice = 1'b0;
      return 1'b1;
    end
    env_mode = MODE_FADE_OUT;
    return 1'b0;
  endfunction

  function automatic env_report_t predict_step(env_request_t r);
    env_report_t rep;
    logic start_p;
    logic stop_p;
    start_p = 1'b0;
    stop_p = 1'b0;
    case (r.action)
      ACT_TICK: begin
        if (!env_voice) begin
          if (env_started)
            void'(stop_voice('0));
        end else if (env_mode != MODE_STOP) begin
          env_acc = add_time(env_acc, r.frame);
          // One tick may walk through several modes; the time restarts on entering fade-in and play.
          if (env_mode == MODE_DELAY && env_acc >= env_delay) begin
            env_acc = '0;
            env_mode = MODE_FADE_IN;
            env_started = 1'b1;
            start_p = 1'b1;
          end
          if (env_mode == MODE_FADE_IN) begin
            if (env_acc >= env_fin) begin
              env_acc = '0;
              env_mode = MODE_PLAY;
              env_gain = cfg_peak;
            end else begin
              env_gain = ramp_gain(env_acc, env_fin);
            end
          end
          if (env_mode == MODE_PLAY) begin
            if (!cfg_loop)
              env_mode = MODE_STOP;
          end else if (env_mode == MODE_FADE_OUT) begin
            if (env_acc >= env_fout) begin
              env_acc = '0;
              env_mode = MODE_STOP;
              env_gain = '0;
              env_started = 1'b0;
              env_voice = 1'b0;
              stop_p = 1'b1;
            end else begin
              env_gain = ramp_gain(env_fout - env_acc, env_fout);
            end
          end
        end
      end
      ACT_PLAY: begin
        if (r.restart) begin
          if (stop_voice('0))
            stop_p = 1'b1;
        end
        env_voice = 1'b1;
        if (r.delay == '0 && r.fade == '0) begin
          env_gain = cfg_peak;
          start_p = 1'b1;
        end
        env_started = 1'b1;
        env_fin = r.fade;
        env_fout = '0;
        env_delay = r.delay;
        env_acc = '0;
        env_mode = MODE_DELAY;
      end
      ACT_STOP: begin
        if (stop_voice(r.fade))
          stop_p = 1'b1;
      end
      default: ;
    endcase
    rep.gain = env_gain;
    rep.mode = env_mode;
    rep.start_p = start_p;
    rep.stop_p = stop_p;
    rep.started = env_started;
    rep.held = env_voice;
    return rep;
  endfunction

  function automatic env_request_t rand_request();
    env_request_t r;
    r.action = 2'($urandom_range(3));
    r.frame = FRAME_W'($urandom());
    r.delay = IN_TIME_W'($urandom());
    r.fade = IN_TIME_W'($urandom());
    r.restart = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic logic [IN_TIME_W-1:0] pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20)
      return '0;
    if (sel < 60)
      return IN_TIME_W'($urandom_range(3000, 1));
    if (sel < 85)
      return IN_TIME_W'($urandom_range(200000, 3001));
    return IN_TIME_W'($urandom());
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10)
      return '0;
    if (sel < 50)
      return FRAME_W'($urandom_range(500, 1));
    if (sel < 90)
      return FRAME_W'($urandom());
    return '1;
  endfunction

  task automatic send_request(env_request_t r, logic typed, env_report_t want);
    env_report_t predicted;
    // The sender never idles inside its quiet stretch.
    while (!(requests_sent >= 250 && requests_sent < 370) && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= r.action;
    in_frame_time <= r.frame;
    in_delay_time <= r.delay;
    in_fade_time <= r.fade;
    in_restart_now <= r.restart;
    do @(posedge clk); while (in_stall);
    predicted = predict_step(r);
    pending_reports.push_back(typed ? want : predicted);
    if (r.action != ACT_UNUSED)
      requests_sent++;
  endtask

  // Registers change only once every outstanding request has its result.
  task automatic configure(logic [GAIN_BITS-1:0] vol, logic loop_en);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_VOLUME;
    cfg_wdata <= vol;
    @(posedge clk);
    cfg_index <= CFG_LOOP_ENABLE;
    cfg_wdata <= CFG_DATA_W'(loop_en);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_peak = vol;
    cfg_loop = loop_en;
    settings_used++;
  endtask

  task automatic random_phase(int n);
    env_request_t r;
    int target;
    int pick;
    target = requests_sent + n;
    while (requests_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        send_request(rand_request(), 1'b0, NO_REPORT);
      end else if (pick < 15) begin
        r = rand_request();
        r.action = ACT_STOP;
        r.fade = pick_length();
        send_request(r, 1'b0, NO_REPORT);
      end else begin
        // A play followed by a run of ticks, now and then cut by a stop.
        r = rand_request();
        r.action = ACT_PLAY;
        r.delay = pick_length();
        r.fade = pick_length();
        r.restart = ($urandom_range(3) == 0);
        send_request(r, 1'b0, NO_REPORT);
        repeat ($urandom_range(12, 1)) begin
          r = rand_request();
          if ($urandom_range(99) < 10) begin
            r.action = ACT_STOP;
            r.fade = pick_length();
          end else begin
            r.action = ACT_TICK;
            r.frame = pick_frame();
          end
          send_request(r, 1'b0, NO_REPORT);
        end
      end
    end
  endtask

  initial begin : stimulus
    env_request_t r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    configure(16'hFFFF, 1'b0);
    for (int i = 0; i < 26; i++)
      send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

    configure(16'd0, 1'b1);
    random_phase(120);
    configure(16'hFFFF, 1'b0);
    random_phase(150);

    // Looping play, then a fade-out of full length: the time saturates at its
    // top value before the release.
    configure(GAIN_BITS'($urandom()), 1'b1);
    r = rand_request();
    r.action = ACT_PLAY;
    r.delay = '0;
    r.fade = '0;
    r.restart = 1'b1;
    send_request(r, 1'b0, NO_REPORT);
    r.action = ACT_TICK;
    r.frame = '0;
    send_request(r, 1'b0, NO_REPORT);
    r.action = ACT_STOP;
    r.fade = '1;
    send_request(r, 1'b0, NO_REPORT);
    repeat (258) begin
      r = rand_request();
      r.action = ACT_TICK;
      r.frame = '1;
      send_request(r, 1'b0, NO_REPORT);
    end

    configure(16'd1, 1'b0);
    random_phase(100);
    configure(GAIN_BITS'($urandom()), 1'($urandom_range(1)));
    random_phase(200);

    in_valid <= 1'b0;
    while (pending_reports.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d requests and %0d checked results over %0d register settings,",
             requests_sent, results_seen, settings_used);
    $display("with ramps, restarts, immediate stops, saturation and a long output hold.");
    if (fail_count == 0 && pending_reports.size() == 0)
      $display("[sound_fade_envelope] OK");
    else
      $display("[sound_fade_envelope] ERROR");
    $finish;
  end

  // Result side: checks each result and decides the stall for the next cycle.
  initial begin : receiver
    env_report_t want;
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTED)
            $display("result %0d arrived with no request outstanding", results_seen);
        end else begin
          want = pending_reports.pop_front();
          if (out_gain !== want.gain || out_mode !== want.mode ||
              out_start_pulse !== want.start_p || out_stop_pulse !== want.stop_p ||
              out_started !== want.started || out_voice_held !== want.held) begin
            fail_count++;
            if (fail_count <= MAX_REPORTED) begin
              $display("result %0d expected gain %h mode %0d start %b stop %b started %b held %b",
                       results_seen, want.gain, want.mode, want.start_p, want.stop_p,
                       want.started, want.held);
              $display("result %0d got      gain %h mode %0d start %b stop %b started %b held %b",
                       results_seen, out_gain, out_mode, out_start_pulse, out_stop_pulse,
                       out_started, out_voice_held);
            end
          end
        end
        results_seen++;
      end
      if (!hold_done && results_seen >= 120) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (results_seen >= 500 && results_seen < 620) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 29);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("No request or result moved for %0d cycles.", STALL_LIMIT);
        $display("[sound_fade_envelope] ERROR");
        $finish;
      end
    end
  end

endmodule
